[sv/multiword_add_carry_prng_core_defines.svh]
// assertion helpers shared by the core
`ifndef MULTIWORD_ADD_CARRY_PRNG_CORE_DEFINES_SVH
`define MULTIWORD_ADD_CARRY_PRNG_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MWAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MWAC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mwac_pkg.sv]
package mwac_pkg;

	localparam int NUM_GENERATORS = 2;
	localparam int WORDS_PER_GEN  = 6;
	localparam int WORD_W         = 32;
	localparam int GEN_W          = 1;
	localparam int STEP_W         = $clog2(WORDS_PER_GEN);
	localparam int WRAP_W         = $clog2(WORDS_PER_GEN);

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [WORDS_PER_GEN-1:0] row_t;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t LAST_STEP = step_t'(WORDS_PER_GEN - 1);

	localparam logic ACT_RESEED = 1'b0;
	localparam logic ACT_DRAW   = 1'b1;

	// element 0 is the first constant added on reseed
	localparam row_t SEED_CONSTS = {
		32'hD1A9FBE7, 32'h97327AE1, 32'h40DDE76D,
		32'h3DF3B646, 32'h96041893, 32'hF22D0E56
	};

	typedef struct packed {
		logic  capture;
		logic  load;
		logic  run;
		logic  store;
		logic  draw;
		step_t step;
	} dp_cmd_t;

endpackage

[sv/mwac_ctrl.sv]
module mwac_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       action,
	input  logic [mwac_pkg::GEN_W-1:0] generator,
	output logic                       busy,
	output logic                       done,
	output mwac_pkg::dp_cmd_t          cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_STORE
	} state_t;

	state_t              state_q;
	mwac_pkg::step_t     step_q;
	logic                action_q;
	logic                done_q;
	logic                gen_ok;
	logic                take;

	assign gen_ok = int'(generator) < mwac_pkg::NUM_GENERATORS;
	assign busy   = (state_q == ST_LOAD) || (state_q == ST_RUN);
	// out-of-range generators are not taken
	assign take   = start && !busy && gen_ok;
	assign done   = done_q;

	assign cmd.capture = take;
	assign cmd.load    = state_q == ST_LOAD;
	assign cmd.run     = state_q == ST_RUN;
	assign cmd.store   = state_q == ST_STORE;
	assign cmd.draw    = action_q;
	assign cmd.step    = step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			action_q <= mwac_pkg::ACT_RESEED;
			done_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q  <= ST_LOAD;
						action_q <= action;
					end
				end
				ST_LOAD: begin
					state_q <= ST_RUN;
					step_q  <= '0;
				end
				ST_RUN: begin
					if (step_q == mwac_pkg::LAST_STEP) begin
						state_q <= ST_STORE;
						done_q  <= action_q == mwac_pkg::ACT_DRAW;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_STORE: begin
					done_q <= 1'b0;
					if (take) begin
						state_q  <= ST_LOAD;
						action_q <= action;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/mwac_datapath.sv]
module mwac_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mwac_pkg::dp_cmd_t           cmd,
	input  logic [mwac_pkg::GEN_W-1:0]  generator,
	input  logic [mwac_pkg::WORD_W-1:0] seed_value,
	output logic [mwac_pkg::WORD_W-1:0] random_value
);

	localparam mwac_pkg::step_t TOP = mwac_pkg::LAST_STEP;

	mwac_pkg::row_t                   rows_q [mwac_pkg::NUM_GENERATORS];
	mwac_pkg::row_t                   wrk_q;
	mwac_pkg::word_t                  acc_q;
	logic                             carry_q;
	logic                             rip_q;
	logic [mwac_pkg::WRAP_W-1:0]      wraps_q;
	logic [mwac_pkg::GEN_W-1:0]       gen_q;

	mwac_pkg::step_t                  wj;
	mwac_pkg::step_t                  lo_idx;
	mwac_pkg::word_t                  opa;
	mwac_pkg::word_t                  opb;
	logic                             cin;
	logic [mwac_pkg::WORD_W:0]        dsum;
	logic                             dcarry;
	mwac_pkg::word_t                  fin;
	logic                             rip_n;
	logic [mwac_pkg::WORD_W:0]        rsum;
	logic [mwac_pkg::WRAP_W-1:0]      wraps_n;

	// draw walks words from the top down, reseed from the bottom up
	always_comb begin
		wj     = TOP - cmd.step;
		lo_idx = (wj == '0) ? '0 : wj - 1'b1;
		opa    = (wj == TOP) ? wrk_q[TOP] : acc_q;
		opb    = wrk_q[lo_idx];
		cin    = (wj == TOP) ? 1'b0 : carry_q;
		dsum   = {1'b0, opa} + {1'b0, opb} + {{mwac_pkg::WORD_W{1'b0}}, cin};
		// top stage takes the true carry, lower stages compare with the addend only
		dcarry = (wj == TOP) ? dsum[mwac_pkg::WORD_W]
		                     : (dsum[mwac_pkg::WORD_W-1:0] < opb);
		// increment ripples down into the already summed word above
		if (wj == TOP) begin
			fin   = wrk_q[TOP] + 1'b1;
			rip_n = &wrk_q[TOP];
		end else begin
			fin   = acc_q + {{(mwac_pkg::WORD_W-1){1'b0}}, rip_q};
			rip_n = rip_q & (&acc_q);
		end
		rsum    = {1'b0, acc_q} + {1'b0, mwac_pkg::SEED_CONSTS[cmd.step]};
		wraps_n = wraps_q + {{(mwac_pkg::WRAP_W-1){1'b0}}, rsum[mwac_pkg::WORD_W]};
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_q   <= seed_value;
			wraps_q <= '0;
			gen_q   <= generator;
		end
		if (cmd.load) begin
			wrk_q <= rows_q[gen_q];
		end
		if (cmd.run) begin
			if (cmd.draw == mwac_pkg::ACT_DRAW) begin
				wrk_q[wj] <= fin;
				rip_q     <= rip_n;
				if (wj != '0) begin
					acc_q   <= dsum[mwac_pkg::WORD_W-1:0];
					carry_q <= dcarry;
				end
			end else begin
				if (cmd.step == TOP) begin
					wrk_q[TOP] <= rsum[mwac_pkg::WORD_W-1:0];
				end else begin
					wrk_q[cmd.step] <= mwac_pkg::word_t'(wraps_n);
					acc_q           <= rsum[mwac_pkg::WORD_W-1:0];
					wraps_q         <= wraps_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < mwac_pkg::NUM_GENERATORS; g++) begin
				rows_q[g] <= '0;
			end
		end else if (cmd.store) begin
			rows_q[gen_q] <= wrk_q;
		end
	end

	assign random_value = wrk_q[0];

endmodule

[sv/multiword_add_carry_prng_core.sv]
// bank of two pseudo-random generators, six 32-bit words each
// input channel: an item is taken at a rising edge with start high and busy low;
//   action 0 reseeds the chosen generator from seed_value, action 1 draws from it
// output channel: done is high for one cycle with random_value valid;
//   a reseed gives no result, and the receiver cannot stall the block
// sequence: after the accepting edge the row of the chosen generator is fetched,
//   six add steps run and the row is written back; done is high in the write-back cycle
// items: a new item can be taken in the write-back cycle of the previous one;
//   the 32-bit datapath handles one word per add step
// reset clears all generator words to zero and returns the controller to idle
// a generator index beyond the bank is not taken
`include "multiword_add_carry_prng_core_defines.svh"

module multiword_add_carry_prng_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [mwac_pkg::GEN_W-1:0]  generator,
	input  logic [mwac_pkg::WORD_W-1:0] seed_value,
	output logic                        done,
	output logic [mwac_pkg::WORD_W-1:0] random_value
);

	mwac_pkg::dp_cmd_t cmd;

	mwac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.generator (generator),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd)
	);

	mwac_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.generator    (generator),
		.seed_value   (seed_value),
		.random_value (random_value)
	);

	`MWAC_ASSERT_NXT(a_done_single, done, !done, "done held longer than one cycle")
	`MWAC_ASSERT_IMP(a_done_free, done, !busy, "done while still busy")
	`MWAC_ASSERT_IMP(a_done_after_work, done, $past(busy), "done without prior work")

endmodule
